@@ hw/rtl/mlbp_pkg.sv @@
// mlbp_pkg: shared types and constants of the led blink and pulse controller
// depends on nothing
`default_nettype none
package mlbp_pkg;
	localparam int LedCount = 10;
	localparam int IdxW = 4;
	localparam int LitW = 10;
	localparam int EntryW = 3 + 16 + 16 + 1 + 1;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_MODE = 3'd1;
	localparam logic [2:0] OP_PULSE = 3'd2;
	localparam logic [2:0] OP_PERIOD = 3'd3;
	localparam logic [2:0] OP_ONTIME = 3'd4;

	localparam logic [2:0] MODE_OFF = 3'd0;
	localparam logic [2:0] MODE_ON = 3'd1;
	localparam logic [2:0] MODE_BLINK = 3'd2;
	localparam logic [2:0] MODE_BLINK_INV = 3'd3;
	localparam logic [2:0] MODE_PULSE_ON = 3'd4;
	localparam logic [2:0] MODE_PULSE_OFF = 3'd5;

	localparam logic [15:0] RESET_PERIOD = 16'd128;
	localparam logic [15:0] RESET_ON_TIME = 16'd64;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] period;
		logic [15:0] on_time;
		logic        req;
		logic        armed;
	} entry_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_EVAL  = 7'b0010000,
		ST_CMD   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

@@ hw/rtl/mlbp_ram.sv @@
// mlbp_ram: generic single port ram with registered read
// depends on nothing
`default_nettype none
module mlbp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/multi_led_blink_pulse_controller_top.sv @@
// multi_led_blink_pulse_controller_top: led blink and pulse controller
// depends on mlbp_pkg and mlbp_ram
//
// Per-led state sits in one ram entry. After reset a clearing pass over all leds
// loads defaults with busy high. A command beat (ops 1 to 4) passes through the
// read, command and done states from start to strobe. A tick walks the leds one
// by one: each takes a read state, a capture step, a 16 step restoring remainder,
// and an evaluate/write state, and the tick then ends in the done state. The
// result strobe is one cycle wide and cannot be stalled.
`default_nettype none
module multi_led_blink_pulse_controller_top
	import mlbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  op,
	input  wire logic [3:0]  led_index,
	input  wire logic [2:0]  mode,
	input  wire logic [15:0] value,
	input  wire logic [15:0] time_ms,
	output logic             done,
	output logic [9:0]       led_lit
);
	state_t state_q;
	logic [IdxW-1:0] idx_q;
	logic [2:0] op_q, mode_q;
	logic [15:0] value_q, time_q;
	logic [15:0] rem_q, quo_q;
	logic [4:0] step_q;
	logic [LedCount-1:0] lit_q;
	entry_t ent_q;

	logic ram_we;
	logic [IdxW-1:0] ram_addr;
	entry_t ram_wdata, ram_rdata;

	mlbp_ram #(.Width(EntryW), .Depth(1 << IdxW)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// one restoring step of the remainder
	logic [16:0] trial;
	assign trial = {rem_q, quo_q[15]} - {1'b0, ent_q.period};

	// evaluation of one led
	entry_t e_new;
	logic lit_new, past, below;
	logic [15:0] rem_f;
	always_comb begin
		rem_f = (ent_q.period == 16'd0) ? 16'd0 : rem_q;
		past = rem_f > ent_q.on_time;
		below = rem_f < ent_q.on_time;
		e_new = ent_q;
		lit_new = lit_q[idx_q];
		case (ent_q.mode)
			MODE_BLINK:     lit_new = !past;
			MODE_BLINK_INV: lit_new = past;
			MODE_PULSE_ON: begin
				if (past) begin
					lit_new = 1'b0;
					e_new.mode = MODE_OFF;
				end
			end
			MODE_PULSE_OFF: begin
				if (past) begin
					lit_new = 1'b1;
					e_new.mode = MODE_ON;
				end
			end
			default: ;
		endcase
		if ((ent_q.req || ent_q.armed) && (e_new.mode inside {MODE_ON, MODE_OFF})) begin
			if (ent_q.armed && below) begin
				lit_new = (e_new.mode == MODE_OFF);
				e_new.mode = (e_new.mode == MODE_OFF) ? MODE_PULSE_ON : MODE_PULSE_OFF;
				e_new.req = 1'b0;
				e_new.armed = 1'b0;
			end else if (ent_q.req && past) begin
				e_new.armed = 1'b1;
			end
		end
	end

	// command update
	entry_t e_cmd;
	always_comb begin
		e_cmd = ram_rdata;
		case (op_q)
			OP_MODE:   e_cmd.mode = mode_q;
			OP_PULSE:  e_cmd.req = 1'b1;
			OP_PERIOD: e_cmd.period = value_q;
			OP_ONTIME: e_cmd.on_time = value_q;
			default: ;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q;
		ram_wdata = e_new;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_wdata = '{mode: MODE_OFF, period: RESET_PERIOD, on_time: RESET_ON_TIME,
					req: 1'b0, armed: 1'b0};
			end
			ST_EVAL: ram_we = 1'b1;
			ST_CMD: begin
				ram_we = 1'b1;
				ram_wdata = e_cmd;
			end
			default: ;
		endcase
	end

	localparam logic [IdxW-1:0] LastIdx = IdxW'(LedCount - 1);
	logic idx_ok;
	assign idx_ok = {1'b0, led_index} < 5'(LedCount);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			lit_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LastIdx) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						op_q <= op;
						mode_q <= mode;
						value_q <= value;
						time_q <= time_ms;
						if (op == OP_TICK) begin
							idx_q <= '0;
							state_q <= ST_READ;
						end else if (idx_ok &&
								(op inside {OP_MODE, OP_PULSE, OP_PERIOD, OP_ONTIME})) begin
							idx_q <= led_index;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					if (op_q == OP_TICK) begin
						rem_q <= '0;
						quo_q <= time_q;
						step_q <= '0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_CMD;
					end
				end
				ST_DIV: begin
					if (step_q == 5'd0) ent_q <= ram_rdata;
					if (step_q != 5'd0) begin
						if (!trial[16]) rem_q <= trial[15:0];
						else rem_q <= {rem_q[14:0], quo_q[15]};
						quo_q <= {quo_q[14:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 5'd16) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					lit_q[idx_q] <= lit_new;
					if (idx_q == LastIdx) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_CMD: begin
					if (op_q == OP_MODE && mode_q == MODE_OFF) lit_q[idx_q] <= 1'b0;
					if (op_q == OP_MODE && mode_q == MODE_ON) lit_q[idx_q] <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	always_comb begin
		led_lit = '0;
		for (int i = 0; i < LedCount && i < LitW; i++) led_lit[i] = lit_q[i];
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("strobe while busy");
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe longer than one cycle");
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> idx_q <= LastIdx) else $error("ram write beyond led count");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
`endif
endmodule
`default_nettype wire
